// ===== rtl/core/sbus_frame_receiver_defines.svh =====
// Assertion macros shared by the frame receiver RTL.
`ifndef SBUS_FRAME_RECEIVER_DEFINES_SVH
`define SBUS_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SFR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SFR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sfr_pkg.sv =====
// Types, constants and register codes of the frame receiver.
`default_nettype none

package sfr_pkg;

  localparam int unsigned FRAME_BYTES    = 25;
  localparam int unsigned NUM_CHANNELS   = 16;
  localparam int unsigned CHAN_BITS      = 11;
  localparam int unsigned CHAN_IDX_BITS  = 4;
  localparam int unsigned PAY_BITS       = NUM_CHANNELS * CHAN_BITS;
  localparam int unsigned PAY_BYTES      = (PAY_BITS + 7) / 8;
  localparam int unsigned FLAG_BYTE      = 23;
  localparam int unsigned FLAG_BITS      = 4;
  localparam int unsigned TIMEOUT_BITS   = 16;
  localparam int unsigned MARKER_BITS    = 8;
  localparam int unsigned COUNT_BITS     = 5;
  localparam int unsigned CFG_INDEX_BITS = 8;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned AGE_BITS_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [COUNT_BITS-1:0]    COUNT_MAX     = '1;
  localparam logic [CHAN_IDX_BITS-1:0] LAST_IDX      = CHAN_IDX_BITS'(NUM_CHANNELS - 1);
  localparam logic [TIMEOUT_BITS-1:0]  RST_TIMEOUT   = 16'd100;
  localparam logic [MARKER_BITS-1:0]   RST_START     = 8'h0F;
  localparam logic [MARKER_BITS-1:0]   RST_END       = 8'h00;
  localparam logic [CHAN_BITS-1:0]     RST_IDLE      = 11'd1024;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START   = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_END     = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IDLE    = 8'd3;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  value;
  } cfg_item_t;

  typedef struct packed {
    logic [CHAN_IDX_BITS-1:0] channel_index;
    logic [CHAN_BITS-1:0]     channel_value;
    logic                     frame_lost;
    logic                     failsafe;
    logic                     digital_a;
    logic                     digital_b;
    logic                     stale;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic [PAY_BITS-1:0]  chans;
    logic [FLAG_BITS-1:0] flags;
    logic                 stale;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/core/sfr_chan_if.sv =====
// Valid/ready channel carrying one payload item per transfer.
`default_nettype none

interface sfr_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sfr_front.sv =====
// Front end: byte window, frame and timeout detection, configuration registers.
`default_nettype none
`include "sbus_frame_receiver_defines.svh"

module sfr_front #(
  parameter int unsigned AGE_BITS = sfr_pkg::AGE_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  sfr_chan_if.sink       in_if,
  sfr_chan_if.sink       cfg_if,
  output sfr_pkg::job_t  job_o,
  output logic           job_valid_o,
  input  wire logic      job_ready_i
);

  localparam int unsigned CMP_W =
    (AGE_BITS > sfr_pkg::TIMEOUT_BITS) ? AGE_BITS : sfr_pkg::TIMEOUT_BITS;

  logic [7:0]                         window_q [sfr_pkg::FRAME_BYTES];
  logic [sfr_pkg::COUNT_BITS-1:0]     cnt_q, cnt_inc;
  logic [AGE_BITS-1:0]                age_q, age_inc;
  logic                               stale_q;
  logic [sfr_pkg::TIMEOUT_BITS-1:0]   timeout_q;
  logic [sfr_pkg::MARKER_BITS-1:0]    start_q, end_q;
  logic [sfr_pkg::CHAN_BITS-1:0]      idle_q;

  logic                               in_fire, is_tick, frame_hit, stale_hit;
  logic [sfr_pkg::PAY_BITS-1:0]       payload;

  assign in_if.ready  = job_ready_i;
  assign cfg_if.ready = 1'b1;
  assign in_fire      = in_if.valid && in_if.ready;
  assign is_tick      = in_if.data.mode == sfr_pkg::MODE_TICK;

  assign cnt_inc = (cnt_q == sfr_pkg::COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
  assign age_inc = (age_q == '1) ? age_q : age_q + 1'b1;

  assign frame_hit = !is_tick && (window_q[1] == start_q) &&
                     (in_if.data.rx_byte == end_q) &&
                     (cnt_inc >= sfr_pkg::COUNT_BITS'(sfr_pkg::FRAME_BYTES));
  assign stale_hit = is_tick && !stale_q && (CMP_W'(age_inc) > CMP_W'(timeout_q));

  // Payload bytes one onward of the shifted window, little-endian.
  always_comb begin
    payload = '0;
    for (int b = 0; b < sfr_pkg::PAY_BYTES; b++) begin
      payload[8*b +: 8] = window_q[b+2];
    end
  end

  always_comb begin
    if (is_tick) begin
      job_o.chans = {sfr_pkg::NUM_CHANNELS{idle_q}};
      job_o.flags = '0;
      job_o.stale = 1'b1;
    end else begin
      job_o.chans = payload;
      job_o.flags = window_q[sfr_pkg::FLAG_BYTE+1][sfr_pkg::FLAG_BITS-1:0];
      job_o.stale = 1'b0;
    end
  end

  assign job_valid_o = in_fire && (frame_hit || stale_hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sfr_pkg::FRAME_BYTES; i++) begin
        window_q[i] <= '0;
      end
      cnt_q   <= '0;
      age_q   <= '1;
      stale_q <= 1'b1;
    end else if (in_fire) begin
      if (is_tick) begin
        age_q <= age_inc;
        if (stale_hit) begin
          stale_q <= 1'b1;
        end
      end else begin
        for (int i = 0; i < sfr_pkg::FRAME_BYTES - 1; i++) begin
          window_q[i] <= window_q[i+1];
        end
        window_q[sfr_pkg::FRAME_BYTES-1] <= in_if.data.rx_byte;
        if (frame_hit) begin
          cnt_q   <= '0;
          age_q   <= '0;
          stale_q <= 1'b0;
        end else begin
          cnt_q <= cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= sfr_pkg::RST_TIMEOUT;
      start_q   <= sfr_pkg::RST_START;
      end_q     <= sfr_pkg::RST_END;
      idle_q    <= sfr_pkg::RST_IDLE;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.data.index)
        sfr_pkg::REG_TIMEOUT: timeout_q <= cfg_if.data.value[sfr_pkg::TIMEOUT_BITS-1:0];
        sfr_pkg::REG_START:   start_q   <= cfg_if.data.value[sfr_pkg::MARKER_BITS-1:0];
        sfr_pkg::REG_END:     end_q     <= cfg_if.data.value[sfr_pkg::MARKER_BITS-1:0];
        sfr_pkg::REG_IDLE:    idle_q    <= cfg_if.data.value[sfr_pkg::CHAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  `SFR_ASSERT_IMP(a_push_room, job_valid_o, job_ready_i, "job pushed without queue room")
  `SFR_ASSERT_NXT(a_frame_clears, in_fire && frame_hit, (cnt_q == '0) && (age_q == '0) && !stale_q, "frame did not clear counters")

endmodule

`default_nettype wire

// ===== rtl/core/sfr_queue.sv =====
// Short register queue of decoded jobs between front and back end.
`default_nettype none
`include "sbus_frame_receiver_defines.svh"

module sfr_queue #(
  parameter int unsigned DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire sfr_pkg::job_t push_data_i,
  output logic               ready_o,
  input  wire logic          pop_i,
  output sfr_pkg::job_t      pop_data_o,
  output logic               valid_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sfr_pkg::job_t     mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign ready_o    = cnt_q != CNT_W'(DEPTH);
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `SFR_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

// ===== rtl/core/sfr_back.sv =====
// Back end: expands one job into sixteen channel results behind an output register.
`default_nettype none
`include "sbus_frame_receiver_defines.svh"

module sfr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire sfr_pkg::job_t job_i,
  output logic               job_pop_o,
  sfr_chan_if.source         out_if
);

  sfr_pkg::job_t                     job_q;
  logic                              busy_q;
  logic [sfr_pkg::CHAN_IDX_BITS-1:0] idx_q;
  logic                              out_valid_q;
  sfr_pkg::out_item_t                out_q, res;
  logic                              adv, at_last;

  assign adv       = !out_valid_q || out_if.ready;
  assign at_last   = idx_q == sfr_pkg::LAST_IDX;
  assign job_pop_o = job_valid_i && (!busy_q || (adv && at_last));

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  always_comb begin
    res.channel_index = idx_q;
    res.channel_value = job_q.chans[idx_q*sfr_pkg::CHAN_BITS +: sfr_pkg::CHAN_BITS];
    res.frame_lost    = job_q.flags[2];
    res.failsafe      = job_q.flags[3];
    res.digital_a     = job_q.flags[0];
    res.digital_b     = job_q.flags[1];
    res.stale         = job_q.stale;
    res.last          = at_last;
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (adv && busy_q) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= busy_q;
        if (busy_q) begin
          idx_q <= idx_q + 1'b1;
          if (at_last) begin
            busy_q <= 1'b0;
          end
        end
      end
      if (job_pop_o) begin
        busy_q <= 1'b1;
      end
    end
  end

  `SFR_ASSERT_IMP(a_idle_idx, !busy_q, idx_q == '0, "index not at zero while idle")
  `SFR_ASSERT_NXT(a_run_end, busy_q && adv && at_last && !job_valid_i, !busy_q && (idx_q == '0), "run did not end after last result")

endmodule

`default_nettype wire

// ===== rtl/core/sbus_frame_receiver.sv =====
// Top level of the 16-channel serial RC frame receiver.
//
// Channels:
//   in_if  - one item per transfer: a received byte (mode 0) or a 1 ms tick (mode 1).
//   cfg_if - register writes (index, value): 0 timeout_ms, 1 start_marker,
//            2 end_marker, 3 idle_value; other indexes are accepted and dropped.
//   out_if - channel results, sixteen per run, last set on channel fifteen.
// A byte that completes a frame starts a run of decoded channels; a tick that
// takes the frame age past timeout_ms starts one run of idle values marked stale.
// Throughput: one input item per cycle while the job queue has room; a run drains
// at one result per cycle while out_if is ready, set by the single result counter
// of the back end. The first result of a run passes a queue entry, the job
// register and the output register of the back end, when the back end is idle.
// A job queue (depth QUEUE_DEPTH, two by default) parts input from output; if out_if
// stalls long enough for the queue to fill, in_if.ready drops until a run ends.
// Reset: registers take their default values, the byte window clears, the
// age saturates and the stale mark is set, so no stale run precedes a frame.
`default_nettype none

module sbus_frame_receiver #(
  parameter int unsigned AGE_BITS    = sfr_pkg::AGE_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sfr_chan_if.sink   in_if,
  sfr_chan_if.sink   cfg_if,
  sfr_chan_if.source out_if
);

  sfr_pkg::job_t push_job, pop_job;
  logic          push_valid, push_ready, pop_valid, pop_req;

  sfr_front #(
    .AGE_BITS (AGE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .cfg_if      (cfg_if),
    .job_o       (push_job),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready)
  );

  sfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_data_i (push_job),
    .ready_o     (push_ready),
    .pop_i       (pop_req),
    .pop_data_o  (pop_job),
    .valid_o     (pop_valid)
  );

  sfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_i       (pop_job),
    .job_pop_o   (pop_req),
    .out_if      (out_if)
  );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench of the serial RC frame receiver: frames, ticks, stale runs, registers.
module tb_top;
  import sfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RAND_PER_PHASE = 8;
  localparam int N_ROWS         = 27;
  localparam int MAX_REPORTS    = 10;

  typedef enum {ROW_FRAME, ROW_TICKS, ROW_BYTE, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [7:0]           sel;
    logic [15:0]          arg;
    logic [7:0]           flg;
    bit                   typed;
    logic [CHAN_BITS-1:0] val;
    bit                   stl;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  sfr_chan_if #(.T(in_item_t))  in_ch  ();
  sfr_chan_if #(.T(cfg_item_t)) cfg_ch ();
  sfr_chan_if #(.T(out_item_t)) out_ch ();

  sbus_frame_receiver dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .cfg_if (cfg_ch),
    .out_if (out_ch)
  );

  // frame: kind, fill or reg index, tick count / byte / reg value, flag byte, typed result
  stim_row_t dir_rows [N_ROWS] = '{
    '{ROW_TICKS, 8'h00,       16'd3,    8'h00, 1'b0, 11'd0,    1'b0},
    '{ROW_BYTE,  8'h00,       16'h00FF, 8'h00, 1'b0, 11'd0,    1'b0},
    '{ROW_BYTE,  8'h00,       16'h0000, 8'h00, 1'b0, 11'd0,    1'b0},
    '{ROW_FRAME, 8'hFF,       16'd0,    8'h0F, 1'b1, 11'd2047, 1'b0},
    '{ROW_FRAME, 8'h00,       16'd0,    8'h00, 1'b1, 11'd0,    1'b0},
    '{ROW_FRAME, 8'hA5,       16'd0,    8'hF5, 1'b0, 11'd0,    1'b0},
    '{ROW_CFG,   REG_TIMEOUT, 16'd0,    8'h00, 1'b0, 11'd0,    1'b0},
    '{ROW_TICKS, 8'h00,       16'd2,    8'h00, 1'b1, 11'd1024, 1'b1},
    '{ROW_CFG,   REG_IDLE,    16'hFFFF, 8'h00, 1'b0, 11'd0,    1'b0},
    '{ROW_FRAME, 8'h3C,       16'd0,    8'h04, 1'b0, 11'd0,    1'b0},
    '{ROW_TICKS, 8'h00,       16'd1,    8'h00, 1'b1, 11'd2047, 1'b1},
    '{ROW_CFG,   REG_START,   16'h00FF, 8'h00, 1'b0, 11'd0,    1'b0},
    '{ROW_CFG,   REG_END,     16'hFFFF, 8'h00, 1'b0, 11'd0,    1'b0},
    '{ROW_FRAME, 8'hC3,       16'd0,    8'h08, 1'b0, 11'd0,    1'b0},
    '{ROW_CFG,   8'hFF,       16'hFFFF, 8'h00, 1'b0, 11'd0,    1'b0},
    '{ROW_CFG,   8'h04,       16'h0000, 8'h00, 1'b0, 11'd0,    1'b0},
    '{ROW_CFG,   REG_IDLE,    16'h0000, 8'h00, 1'b0, 11'd0,    1'b0},
    '{ROW_CFG,   REG_TIMEOUT, 16'hFFFF, 8'h00, 1'b0, 11'd0,    1'b0},
    '{ROW_FRAME, 8'h81,       16'd0,    8'hFF, 1'b0, 11'd0,    1'b0},
    '{ROW_TICKS, 8'h00,       16'd10,   8'h00, 1'b0, 11'd0,    1'b0},
    '{ROW_CFG,   REG_TIMEOUT, 16'd3,    8'h00, 1'b0, 11'd0,    1'b0},
    '{ROW_TICKS, 8'h00,       16'd3,    8'h00, 1'b1, 11'd0,    1'b1},
    '{ROW_CFG,   REG_START,   16'h0000, 8'h00, 1'b0, 11'd0,    1'b0},
    '{ROW_CFG,   REG_END,     16'h0000, 8'h00, 1'b0, 11'd0,    1'b0},
    '{ROW_FRAME, 8'h00,       16'd0,    8'h00, 1'b1, 11'd0,    1'b0},
    '{ROW_CFG,   REG_START,   16'h000F, 8'h00, 1'b0, 11'd0,    1'b0},
    '{ROW_CFG,   REG_END,     16'h0000, 8'h00, 1'b0, 11'd0,    1'b0}
  };

  logic [7:0]              rx_win [FRAME_BYTES];
  logic [COUNT_BITS-1:0]   rx_count;
  logic [AGE_BITS_DEF-1:0] tick_age;
  bit                      idle_sent;
  logic [TIMEOUT_BITS-1:0] t_timeout;
  logic [MARKER_BITS-1:0]  t_start;
  logic [MARKER_BITS-1:0]  t_end;
  logic [CHAN_BITS-1:0]    t_idle;

  out_item_t  decoded_run [NUM_CHANNELS];
  out_item_t  chan_q [$];
  logic [7:0] frame_buf [FRAME_BYTES];

  bit                   typed_on;
  logic [CHAN_BITS-1:0] typed_val;
  logic [3:0]           typed_flg;
  bit                   typed_stale;

  int   bad = 0;
  int   quiet = 0;
  int   item_count = 0;
  int   burst_left = 10;
  bit   no_gaps = 1'b0;
  bit   in_held = 1'b0;
  bit   hold_req = 1'b0;
  logic [15:0] stall_pat;
  int   pat_left;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int decode_item(input in_item_t it);
    logic [FRAME_BYTES*8-1:0] flat;
    logic [7:0] fb;
    int k;
    if (it.mode == MODE_TICK) begin
      if (tick_age != '1) tick_age++;
      if (idle_sent || tick_age <= t_timeout) return 0;
      idle_sent = 1'b1;
      for (k = 0; k < NUM_CHANNELS; k++)
        decoded_run[k] = '{channel_index: 4'(k), channel_value: t_idle, frame_lost: 1'b0,
                           failsafe: 1'b0, digital_a: 1'b0, digital_b: 1'b0, stale: 1'b1,
                           last: (k == NUM_CHANNELS - 1)};
      return NUM_CHANNELS;
    end
    for (k = 0; k < FRAME_BYTES - 1; k++) rx_win[k] = rx_win[k+1];
    rx_win[FRAME_BYTES-1] = it.rx_byte;
    if (rx_count != COUNT_MAX) rx_count++;
    if (rx_win[0] != t_start || rx_win[FRAME_BYTES-1] != t_end || rx_count < FRAME_BYTES)
      return 0;
    for (k = 0; k < FRAME_BYTES; k++) flat[8*k +: 8] = rx_win[k];
    fb = rx_win[FLAG_BYTE];
    for (k = 0; k < NUM_CHANNELS; k++)
      decoded_run[k] = '{channel_index: 4'(k),
                         channel_value: flat[8 + CHAN_BITS*k +: CHAN_BITS],
                         frame_lost: fb[2], failsafe: fb[3], digital_a: fb[0],
                         digital_b: fb[1], stale: 1'b0, last: (k == NUM_CHANNELS - 1)};
    rx_count  = '0;
    tick_age  = '0;
    idle_sent = 1'b0;
    return NUM_CHANNELS;
  endfunction

  function automatic logic [7:0] noise_byte();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return t_start;
    if (sel == 1) return t_end;
    return 8'($urandom);
  endfunction

  function automatic void build_frame(input bit rnd, input logic [7:0] fill,
                                      input logic [7:0] flg);
    int k;
    frame_buf[0] = t_start;
    for (k = 1; k < FLAG_BYTE; k++) frame_buf[k] = rnd ? 8'($urandom) : fill;
    frame_buf[FLAG_BYTE] = flg;
    frame_buf[FRAME_BYTES-1] = t_end;
  endfunction

  task automatic push_item(input in_item_t it);
    int n;
    int k;
    out_item_t r;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    in_held = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    item_count++;
    n = decode_item(it);
    for (k = 0; k < n; k++) begin
      if (typed_on) begin
        r = '{channel_index: 4'(k), channel_value: typed_val, frame_lost: typed_flg[2],
              failsafe: typed_flg[3], digital_a: typed_flg[0], digital_b: typed_flg[1],
              stale: typed_stale, last: (k == NUM_CHANNELS - 1)};
      end else begin
        r = decoded_run[k];
      end
      chan_q.push_back(r);
    end
    if (!no_gaps) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_ch.valid <= 1'b0;
        in_held = 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 3) == 0) ? 120 : $urandom_range(1, 40);
      end
    end
  endtask

  task automatic send_frame(input int len);
    int k;
    for (k = 0; k < len; k++) push_item(in_item_t'{mode: MODE_BYTE, rx_byte: frame_buf[k]});
  endtask

  task automatic settle();
    if (in_held) begin
      in_ch.valid <= 1'b0;
      in_held = 1'b0;
    end
    while (chan_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cfg_item_t'{index: idx, value: val};
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_TIMEOUT: t_timeout = val;
      REG_START:   t_start = val[MARKER_BITS-1:0];
      REG_END:     t_end = val[MARKER_BITS-1:0];
      REG_IDLE:    t_idle = val[CHAN_BITS-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (chan_q.size() == 0) begin
        bad++;
        if (bad <= MAX_REPORTS)
          $display("unexpected result: idx %0d val %0d stale %b last %b",
                   got.channel_index, got.channel_value, got.stale, got.last);
      end else begin
        want = chan_q.pop_front();
        if (got.channel_index !== want.channel_index ||
            got.channel_value !== want.channel_value ||
            got.frame_lost !== want.frame_lost || got.failsafe !== want.failsafe ||
            got.digital_a !== want.digital_a || got.digital_b !== want.digital_b ||
            got.stale !== want.stale || got.last !== want.last) begin
          bad++;
          if (bad <= MAX_REPORTS)
            $display("mismatch: exp idx %0d val %0d fl %b fs %b a %b b %b st %b last %b",
                     want.channel_index, want.channel_value, want.frame_lost,
                     want.failsafe, want.digital_a, want.digital_b, want.stale, want.last,
                     " / got idx %0d val %0d fl %b fs %b a %b b %b st %b last %b",
                     got.channel_index, got.channel_value, got.frame_lost,
                     got.failsafe, got.digital_a, got.digital_b, got.stale, got.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
        (out_ch.valid && out_ch.ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    pat_left = 0;
    stall_pat = '1;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (pat_left == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pat = '1;
            1: stall_pat = 16'($urandom) | 16'h1;
            2: stall_pat = 16'($urandom | $urandom) | 16'h1;
            default: stall_pat = 16'($urandom & $urandom) | 16'h1;
          endcase
          pat_left = 64;
        end
        out_ch.ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
        pat_left--;
      end
    end
  end

  initial begin
    int r;
    int phase;
    int pick;
    int target;
    logic [TIMEOUT_BITS-1:0] tmo;
    logic [MARKER_BITS-1:0]  sm;
    logic [MARKER_BITS-1:0]  em;

    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    typed_on     = 1'b0;
    t_timeout    = RST_TIMEOUT;
    t_start      = RST_START;
    t_end        = RST_END;
    t_idle       = RST_IDLE;
    foreach (rx_win[k]) rx_win[k] = '0;
    rx_count  = '0;
    tick_age  = '1;
    idle_sent = 1'b1;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (r = 0; r < N_ROWS; r++) begin
      typed_on    = dir_rows[r].typed;
      typed_val   = dir_rows[r].val;
      typed_stale = dir_rows[r].stl;
      typed_flg   = dir_rows[r].stl ? 4'h0 : dir_rows[r].flg[3:0];
      case (dir_rows[r].kind)
        ROW_FRAME: begin
          build_frame(1'b0, dir_rows[r].sel, dir_rows[r].flg);
          send_frame(FRAME_BYTES);
        end
        ROW_TICKS:
          repeat (dir_rows[r].arg)
            push_item(in_item_t'{mode: MODE_TICK, rx_byte: 8'($urandom)});
        ROW_BYTE: push_item(in_item_t'{mode: MODE_BYTE, rx_byte: dir_rows[r].arg[7:0]});
        default: write_reg(dir_rows[r].sel, dir_rows[r].arg);
      endcase
    end
    typed_on = 1'b0;

    // stall the output while frames keep coming, so the job queue backs up
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    repeat (4) begin
      build_frame(1'b1, 8'h00, 8'($urandom));
      send_frame(FRAME_BYTES);
    end
    no_gaps = 1'b0;

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          tmo = 16'($urandom_range(1, 40));
          sm  = RST_START;
          em  = RST_END;
        end
        1: begin
          tmo = '0;
          sm  = 8'($urandom);
          em  = 8'($urandom);
        end
        2: begin
          tmo = '1;
          sm  = 8'hFF;
          em  = 8'hFF;
        end
        default: begin
          tmo = 16'($urandom_range(1, 8));
          sm  = 8'($urandom);
          em  = 8'($urandom);
        end
      endcase
      write_reg(REG_TIMEOUT, tmo);
      write_reg(REG_START, {8'($urandom), sm});
      write_reg(REG_END, {8'($urandom), em});
      write_reg(REG_IDLE, 16'($urandom));
      write_reg(8'($urandom_range(4, 255)), 16'($urandom));
      target = item_count + RAND_PER_PHASE;
      while (item_count < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          repeat ($urandom_range(0, 2))
            push_item(in_item_t'{mode: MODE_BYTE, rx_byte: noise_byte()});
          build_frame(1'b1, 8'h00, 8'($urandom));
          send_frame(FRAME_BYTES);
        end else if (pick < 70) begin
          build_frame(1'b1, 8'h00, 8'($urandom));
          if ($urandom_range(0, 1) == 1) begin
            frame_buf[$urandom_range(0, FRAME_BYTES - 1)] = 8'($urandom);
            send_frame(FRAME_BYTES);
          end else begin
            send_frame($urandom_range(1, FRAME_BYTES - 1));
          end
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 50))
            push_item(in_item_t'{mode: MODE_TICK, rx_byte: 8'($urandom)});
        end else begin
          repeat ($urandom_range(1, 40))
            push_item(in_item_t'{mode: MODE_BYTE, rx_byte: noise_byte()});
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (bad == 0 && chan_q.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
